[design/pak_pkg.sv]
// polar arm kinematics package: fixed-point formats, cordic tables, pipeline structs
// and the saturation helper; no dependencies
package pak_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int FRACTION_BITS = 16;

    localparam int RAD_SHIFT  = FRACTION_BITS + 16;
    localparam int POS_SHIFT  = 46 - FRACTION_BITS;
    localparam int ANG_SHIFT  = 48;
    localparam int GAIN_SHIFT = 48;

    localparam int VW = 52;
    localparam int RW = 36;
    localparam int AW = 34;

    localparam logic [31:0] INV_GAIN = 32'd2608131496;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef enum logic [1:0] {
        REG_THETA_SPT = 2'd0,
        REG_TURNS_PTS = 2'd1,
        REG_RADIUS_SPM = 2'd2,
        REG_MM_PRS    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
        logic [31:0]          vz;
        logic signed [RW-1:0] rx;
        logic signed [RW-1:0] ry;
        logic signed [AW-1:0] ra;
    } cord_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] x;
        logic [31:0] y;
        logic        yz;
        logic        xz;
        logic [1:0]  quad;
        logic        quarter;
        logic        flip;
        logic        dneg;
        logic [63:0] dmag;
    } side_t;

    function automatic logic [31:0] sat32(input logic neg, input logic [67:0] q);
        logic [31:0] res;
        if (neg) begin
            if (q >= 68'h80000000) res = 32'h80000000;
            else                   res = 32'(68'd0 - q);
        end else begin
            if (q > 68'h7FFFFFFF)  res = 32'h7FFFFFFF;
            else                   res = q[31:0];
        end
        return res;
    endfunction

endpackage

[design/pak_cordic.sv]
// cordic pipeline: one register stage per iteration, vectoring and rotation side by side
// depends on pak_pkg
module pak_cordic import pak_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  cord_t in_cord,
    input  side_t in_side,
    output logic  out_valid,
    output cord_t out_cord,
    output side_t out_side
);

    logic [CORDIC_N:0] valid_reg;
    cord_t cord_reg [CORDIC_N+1];
    side_t side_reg [CORDIC_N+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[CORDIC_N-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cord_reg[0] <= in_cord;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 1; i <= CORDIC_N; i++) begin : g_stage
        cord_t cord_next;
        logic signed [VW-1:0] vx, vy;
        logic signed [RW-1:0] rx, ry;
        logic signed [AW-1:0] ra;

        always_comb begin
            vx = cord_reg[i-1].vx;
            vy = cord_reg[i-1].vy;
            rx = cord_reg[i-1].rx;
            ry = cord_reg[i-1].ry;
            ra = cord_reg[i-1].ra;
            cord_next = cord_reg[i-1];
            if (!vy[VW-1]) begin
                cord_next.vx = vx + (vy >>> (i-1));
                cord_next.vy = vy - (vx >>> (i-1));
                cord_next.vz = cord_reg[i-1].vz + ATAN_TURNS[i-1];
            end else begin
                cord_next.vx = vx - (vy >>> (i-1));
                cord_next.vy = vy + (vx >>> (i-1));
                cord_next.vz = cord_reg[i-1].vz - ATAN_TURNS[i-1];
            end
            if (!ra[AW-1]) begin
                cord_next.rx = rx - (ry >>> (i-1));
                cord_next.ry = ry + (rx >>> (i-1));
                cord_next.ra = ra - $signed({2'b00, ATAN_TURNS[i-1]});
            end else begin
                cord_next.rx = rx + (ry >>> (i-1));
                cord_next.ry = ry - (rx >>> (i-1));
                cord_next.ra = ra + $signed({2'b00, ATAN_TURNS[i-1]});
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                cord_reg[i] <= cord_next;
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_N];
    assign out_cord  = cord_reg[CORDIC_N];
    assign out_side  = side_reg[CORDIC_N];

endmodule

[design/polar_arm_kinematics.sv]
// Polar arm kinematics converter. Inverse mode turns x/y into theta and radius step
// counts, forward mode turns step counts into x/y. Fully pipelined: one transaction per
// cycle through input register, scaling multipliers, cordic iterations, rounding and
// output scaling; the whole pipe holds while the output stalls.
// depends on pak_pkg and pak_cordic
module polar_arm_kinematics import pak_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // in_x, in_y, in_theta_steps, in_radius_steps
    input  logic         s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_theta_steps, out_radius_steps, out_x, out_y
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    logic [31:0] tspt_reg, tpts_reg, rspm_reg, mmprs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tspt_reg  <= 32'd13107200;
            tpts_reg  <= 32'd21475;
            rspm_reg  <= 32'd5242880;
            mmprs_reg <= 32'd819;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_THETA_SPT:  tspt_reg  <= cfg_wdata;
                REG_TURNS_PTS:  tpts_reg  <= cfg_wdata;
                REG_RADIUS_SPM: rspm_reg  <= cfg_wdata;
                REG_MM_PRS:     mmprs_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic adv;
    logic m_valid_reg;
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // input register
    logic        v0_reg, mode0_reg;
    logic [31:0] x0_reg, y0_reg, th0_reg, rs0_reg;
    // scaling products
    logic        v1_reg, mode1_reg;
    logic [31:0] x1_reg, y1_reg, z1_reg;
    logic [63:0] d1_reg;
    logic [31:0] zfull;
    logic signed [63:0] dfull;

    assign zfull = th0_reg * tpts_reg;
    assign dfull = $signed({{32{rs0_reg[31]}}, rs0_reg}) * $signed({32'd0, mmprs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode0_reg <= s_tuser;
            x0_reg    <= s_tdata[31:0];
            y0_reg    <= s_tdata[63:32];
            th0_reg   <= s_tdata[95:64];
            rs0_reg   <= s_tdata[127:96];
            mode1_reg <= mode0_reg;
            x1_reg    <= x0_reg;
            y1_reg    <= y0_reg;
            z1_reg    <= zfull;
            d1_reg    <= dfull;
        end
    end

    // cordic set-up
    cord_t cin;
    side_t sin_c;
    logic signed [VW-1:0] xs, ys;
    logic [1:0]  zq;
    logic        zflip;
    logic [31:0] zf;

    always_comb begin
        xs = {{4{x1_reg[31]}}, x1_reg, 16'd0};
        ys = {{4{y1_reg[31]}}, y1_reg, 16'd0};
        zq = z1_reg[31:30];
        zflip = (zq == 2'd1) || (zq == 2'd2);
        zf = z1_reg ^ {zflip, 31'd0};
        cin.vx = x1_reg[31] ? -xs : xs;
        cin.vy = x1_reg[31] ? -ys : ys;
        cin.vz = x1_reg[31] ? 32'h80000000 : 32'd0;
        cin.rx = $signed({4'd0, INV_GAIN});
        cin.ry = '0;
        cin.ra = $signed({{2{zf[31]}}, zf});
        sin_c.mode    = mode1_reg;
        sin_c.x       = x1_reg;
        sin_c.y       = y1_reg;
        sin_c.yz      = (y1_reg == 32'd0);
        sin_c.xz      = (x1_reg == 32'd0);
        sin_c.quad    = zq;
        sin_c.quarter = (z1_reg[29:0] == 30'd0);
        sin_c.flip    = zflip;
        sin_c.dneg    = d1_reg[63];
        sin_c.dmag    = d1_reg[63] ? (64'd0 - d1_reg) : d1_reg;
    end

    logic  cv;
    cord_t co;
    side_t so;

    pak_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v1_reg),
        .in_cord   (cin),
        .in_side   (sin_c),
        .out_valid (cv),
        .out_cord  (co),
        .out_side  (so)
    );

    // post stage 1: angle fix-up, gain product, cos/sin rounding
    logic signed [AW-1:0] a_next;
    logic [32:0] amag_next, rspec_next;
    logic        spec_next;
    logic        ypos;
    logic [RW-1:0] rxm, rym, cm_full, sm_full;
    logic [31:0] cmag_next, smag_next;
    logic        cneg_next, sneg_next;

    always_comb begin
        ypos = !so.y[31] && !so.yz;
        a_next = $signed({{2{co.vz[31]}}, co.vz});
        if (ypos && a_next < 0)    a_next = a_next + 34'sd4294967296;
        if (so.y[31] && a_next > 0) a_next = a_next - 34'sd4294967296;
        spec_next  = so.yz || so.xz;
        rspec_next = '0;
        if (so.yz) begin
            a_next = so.x[31] ? 34'sd2147483648 : 34'sd0;
            rspec_next = so.x[31] ? (33'd0 - {1'b1, so.x}) : {1'b0, so.x};
        end else if (so.xz) begin
            a_next = ypos ? 34'sd1073741824 : -34'sd1073741824;
            rspec_next = so.y[31] ? (33'd0 - {1'b1, so.y}) : {1'b0, so.y};
        end
        amag_next = a_next[AW-1] ? 33'(-a_next) : 33'(a_next);

        rxm = co.rx[RW-1] ? RW'(-co.rx) : RW'(co.rx);
        rym = co.ry[RW-1] ? RW'(-co.ry) : RW'(co.ry);
        cm_full = (rxm + RW'(2)) >> 2;
        sm_full = (rym + RW'(2)) >> 2;
        cmag_next = cm_full[31:0];
        smag_next = sm_full[31:0];
        cneg_next = (cm_full != '0) && (co.rx[RW-1] ^ so.flip);
        sneg_next = (sm_full != '0) && (co.ry[RW-1] ^ so.flip);
        if (so.quarter) begin
            cmag_next = (so.quad == 2'd0 || so.quad == 2'd2) ? 32'h40000000 : 32'd0;
            smag_next = (so.quad == 2'd1 || so.quad == 2'd3) ? 32'h40000000 : 32'd0;
            cneg_next = (so.quad == 2'd2);
            sneg_next = (so.quad == 2'd3);
        end
    end

    logic        v2_reg, mode2_reg, aneg2_reg, spec2_reg, cneg2_reg, sneg2_reg, dneg2_reg;
    logic [32:0] amag2_reg, rspec2_reg;
    logic [63:0] plo2_reg, dmag2_reg;
    logic [51:0] phi2_reg;
    logic [31:0] cmag2_reg, smag2_reg;

    // post stage 2: radius rounding, position partial products
    logic        v3_reg, mode3_reg, aneg3_reg, xneg3_reg, yneg3_reg;
    logic [32:0] amag3_reg;
    logic [33:0] r3_reg;
    logic [63:0] pxl3_reg, pxh3_reg, pyl3_reg, pyh3_reg;
    logic [83:0] gsum;

    assign gsum = {phi2_reg, 32'd0} + {20'd0, plo2_reg} + (84'd1 << (GAIN_SHIFT - 1));

    // post stage 3: step products, position sums
    logic        v4_reg, mode4_reg, aneg4_reg, thi4_reg, xneg4_reg, yneg4_reg;
    logic [63:0] tprod4_reg, rprod4_reg;
    logic [33:0] rhip4_reg;
    logic [95:0] xs4_reg, ys4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= cv;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode2_reg  <= so.mode;
            aneg2_reg  <= a_next[AW-1];
            amag2_reg  <= amag_next;
            spec2_reg  <= spec_next;
            rspec2_reg <= rspec_next;
            plo2_reg   <= 64'(co.vx[31:0]) * 64'(INV_GAIN);
            phi2_reg   <= 52'(co.vx[VW-1:32]) * 52'(INV_GAIN);
            cneg2_reg  <= cneg_next;
            sneg2_reg  <= sneg_next;
            cmag2_reg  <= cmag_next;
            smag2_reg  <= smag_next;
            dneg2_reg  <= so.dneg;
            dmag2_reg  <= so.dmag;

            mode3_reg <= mode2_reg;
            aneg3_reg <= aneg2_reg;
            amag3_reg <= amag2_reg;
            r3_reg    <= spec2_reg ? {1'b0, rspec2_reg} : gsum[GAIN_SHIFT +: 34];
            xneg3_reg <= dneg2_reg != cneg2_reg;
            yneg3_reg <= dneg2_reg != sneg2_reg;
            pxl3_reg  <= 64'(dmag2_reg[31:0]) * 64'(cmag2_reg);
            pxh3_reg  <= 64'(dmag2_reg[63:32]) * 64'(cmag2_reg);
            pyl3_reg  <= 64'(dmag2_reg[31:0]) * 64'(smag2_reg);
            pyh3_reg  <= 64'(dmag2_reg[63:32]) * 64'(smag2_reg);

            mode4_reg  <= mode3_reg;
            aneg4_reg  <= aneg3_reg;
            thi4_reg   <= amag3_reg[32];
            tprod4_reg <= 64'(amag3_reg[31:0]) * 64'(tspt_reg);
            rprod4_reg <= 64'(r3_reg[31:0]) * 64'(rspm_reg);
            rhip4_reg  <= 34'(r3_reg[33:32]) * 34'(rspm_reg);
            xneg4_reg  <= xneg3_reg;
            yneg4_reg  <= yneg3_reg;
            xs4_reg    <= {pxh3_reg, 32'd0} + {32'd0, pxl3_reg};
            ys4_reg    <= {pyh3_reg, 32'd0} + {32'd0, pyl3_reg};
        end
    end

    // post stage 4: rounding and saturation into the output register
    logic [65:0] tsum, rsum;
    logic [95:0] xsum, ysum;
    logic [127:0] out_next;

    always_comb begin
        tsum = 66'(tprod4_reg) + (thi4_reg ? {2'b00, tspt_reg, 32'd0} : 66'd0)
             + (66'd1 << (ANG_SHIFT - 1));
        rsum = 66'(rprod4_reg) + {rhip4_reg, 32'd0} + (66'd1 << (RAD_SHIFT - 1));
        xsum = xs4_reg + (96'd1 << (POS_SHIFT - 1));
        ysum = ys4_reg + (96'd1 << (POS_SHIFT - 1));
        out_next = '0;
        if (mode4_reg) begin
            out_next[95:64]  = sat32(xneg4_reg, 68'(xsum >> POS_SHIFT));
            out_next[127:96] = sat32(yneg4_reg, 68'(ysum >> POS_SHIFT));
        end else begin
            out_next[31:0]   = sat32(aneg4_reg, 68'(tsum >> ANG_SHIFT));
            out_next[63:32]  = sat32(1'b0, 68'(rsum >> RAD_SHIFT));
        end
    end

    logic [127:0] m_data_reg;
    logic         m_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= out_next;
            m_mode_reg <= mode4_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_fwd_zero_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_mode_reg |-> m_tdata[63:0] == 64'd0)
        else $error("forward transaction carries step counts");
    a_inv_zero_xy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_mode_reg |-> m_tdata[127:64] == 64'd0)
        else $error("inverse transaction carries a position");
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input held off without an output stall");
`endif

endmodule
